FILE: rtl/assert_macros.svh
// Assertion macros shared by the escaper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/uje_pkg.sv
// Types, constants and helpers shared by the JSON string escaper modules.
package uje_pkg;

    localparam int CP_W = 21;

    // One code point handed from the decoder to the expander.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [3:0][7:0]  src_bytes;
        logic [2:0]       src_count;
        logic             run_last;
        logic             string_done;
    } uje_job_t;

    // Characters of the escaped text.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // Code points with a two-character escape.
    localparam logic [CP_W-1:0] CP_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CP_QUOTE  = 21'h22;
    localparam logic [CP_W-1:0] CP_BS     = 21'h08;
    localparam logic [CP_W-1:0] CP_FF     = 21'h0C;
    localparam logic [CP_W-1:0] CP_LF     = 21'h0A;
    localparam logic [CP_W-1:0] CP_CR     = 21'h0D;
    localparam logic [CP_W-1:0] CP_TAB    = 21'h09;

    localparam logic [CP_W-1:0] CP_CTRL_MAX  = 21'h1F;
    localparam logic [CP_W-1:0] CP_PRINT_MIN = 21'h20;
    localparam logic [CP_W-1:0] CP_PRINT_MAX = 21'h7E;
    localparam logic [CP_W-1:0] CP_BMP_MAX   = 21'hFFFF;
    localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h10000;
    localparam logic [15:0]     HI_SURR_BASE = 16'hD800;
    localparam logic [15:0]     LO_SURR_BASE = 16'hDC00;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        begin
            if (nib < 4'd10)
            begin
                ch = 8'h30 + {4'b0, nib};
            end
            else
            begin
                ch = 8'h57 + {4'b0, nib};
            end
            return ch;
        end
    endfunction

endpackage

FILE: rtl/uje_job_fifo.sv
// Small register queue of decoded code points between decoder and expander.
`include "assert_macros.svh"

module uje_job_fifo
    import uje_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  uje_job_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output uje_job_t rd_data,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uje_job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, wr_en && full, "job queue written while full")
    `ASSERT_NEVER(a_fifo_underflow, rd_en && empty, "job queue read while empty")

endmodule

FILE: rtl/uje_front.sv
// Input side: lenient UTF-8 decoder that turns each byte into zero to four code points.
`include "assert_macros.svh"

module uje_front
    import uje_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic [7:0] in_byte,
    input  logic     end_of_string,
    input  logic     push,
    output logic     full,
    output uje_job_t job_data,
    output logic     job_push,
    input  logic     job_full
);

    // Code points one input byte gives: either one whole sequence, or a run
    // of lone bytes (held bytes first, then possibly the new byte).
    typedef struct packed {
        logic [3:0][7:0]  bytes;
        logic [2:0]       cnt;
        logic             full_seq;
        logic [2:0]       src_n;
        logic [CP_W-1:0]  cp;
        logic             eos;
    } run_list_t;

    logic [7:0]       pend_reg [3];
    logic [1:0]       pc_reg;
    logic [1:0]       pc_next;
    logic [1:0]       exp_reg;
    logic [1:0]       exp_next;
    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;

    run_list_t        list_reg;
    run_list_t        new_list;
    run_list_t        cur_list;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic [2:0]       cur_idx;
    logic             busy_reg;
    logic             busy_next;

    logic             accept;
    logic             is_cont;
    logic             is_lead;
    logic [1:0]       lead_extra;
    logic [CP_W-1:0]  lead_val;
    logic [CP_W-1:0]  cont_val;
    logic             do_hold;
    logic             do_fresh;
    logic [7:0]       lone_byte;
    logic             job_last;

    assign full   = busy_reg;
    assign accept = push && !busy_reg;

    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign cont_val = {partial_reg[CP_W-7:0], in_byte[5:0]};

    always_comb
    begin
        is_lead    = 1'b1;
        lead_extra = 2'd0;
        lead_val   = '0;
        if (in_byte[7:5] == 3'b110)
        begin
            lead_extra = 2'd1;
            lead_val   = {16'b0, in_byte[4:0]};
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            lead_extra = 2'd2;
            lead_val   = {17'b0, in_byte[3:0]};
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            lead_extra = 2'd3;
            lead_val   = {18'b0, in_byte[2:0]};
        end
        else
        begin
            is_lead = 1'b0;
        end
    end

    // Decode the new byte against the held sequence.
    always_comb
    begin
        new_list.bytes[0] = (pc_reg > 2'd0) ? pend_reg[0] : in_byte;
        new_list.bytes[1] = (pc_reg > 2'd1) ? pend_reg[1] : in_byte;
        new_list.bytes[2] = (pc_reg > 2'd2) ? pend_reg[2] : in_byte;
        new_list.bytes[3] = in_byte;
        new_list.src_n    = {1'b0, pc_reg} + 3'd1;
        new_list.cp       = cont_val;
        new_list.eos      = end_of_string;
        new_list.full_seq = 1'b0;
        new_list.cnt      = 3'd0;
        pc_next           = '0;
        exp_next          = '0;
        partial_next      = '0;
        do_hold           = 1'b0;
        do_fresh          = 1'b0;

        if (pc_reg != 2'd0 && is_cont)
        begin
            if (pc_reg == exp_reg)
            begin
                new_list.full_seq = 1'b1;
                new_list.cnt      = 3'd1;
            end
            else if (end_of_string || pc_reg == 2'd3)
            begin
                new_list.cnt = {1'b0, pc_reg} + 3'd1;
            end
            else
            begin
                do_hold      = 1'b1;
                pc_next      = pc_reg + 2'd1;
                exp_next     = exp_reg;
                partial_next = cont_val;
            end
        end
        else if (is_lead && !end_of_string)
        begin
            // Held bytes go out as lone units and the lead starts a new sequence.
            new_list.cnt = {1'b0, pc_reg};
            do_fresh     = 1'b1;
            pc_next      = 2'd1;
            exp_next     = lead_extra;
            partial_next = lead_val;
        end
        else
        begin
            new_list.cnt = {1'b0, pc_reg} + 3'd1;
        end
    end

    assign cur_list  = accept ? new_list : list_reg;
    assign cur_idx   = accept ? 3'd0 : idx_reg;
    assign job_push  = (cur_idx < cur_list.cnt) && !job_full;
    assign idx_next  = cur_idx + {2'b0, job_push};
    assign busy_next = (idx_next < cur_list.cnt);
    assign lone_byte = cur_list.bytes[cur_idx[1:0]];
    assign job_last  = (cur_idx == cur_list.cnt - 3'd1);

    always_comb
    begin
        job_data.run_last    = job_last;
        job_data.string_done = job_last && cur_list.eos;
        if (cur_list.full_seq)
        begin
            job_data.code_point = cur_list.cp;
            job_data.src_bytes  = cur_list.bytes;
            job_data.src_count  = cur_list.src_n;
        end
        else
        begin
            job_data.code_point   = {13'b0, lone_byte};
            job_data.src_bytes    = '0;
            job_data.src_bytes[0] = lone_byte;
            job_data.src_count    = 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            exp_reg     <= '0;
            partial_reg <= '0;
            list_reg    <= '0;
            idx_reg     <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pc_reg      <= pc_next;
                exp_reg     <= exp_next;
                partial_reg <= partial_next;
                list_reg    <= new_list;
            end
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_hold)
        begin
            pend_reg[pc_reg] <= in_byte;
        end
        else if (accept && do_fresh)
        begin
            pend_reg[0] <= in_byte;
        end
    end

    `ASSERT_CLK(a_pend_le_expected, pc_reg <= exp_reg,
        "more bytes held than the lead byte calls for")
    `ASSERT_CLK(a_busy_has_work, busy_reg |-> (idx_reg < list_reg.cnt),
        "input held off with no code point left to send")

endmodule

FILE: rtl/uje_back.sv
// Output side: expands each code point into escaped JSON text, one byte per cycle unless stalled.
`include "assert_macros.svh"

module uje_back
    import uje_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       ensure_ascii,
    input  uje_job_t   job_data,
    input  logic       job_empty,
    output logic       job_pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done,
    output logic       empty,
    input  logic       pop
);

    typedef enum logic [1:0] {
        MODE_SHORT,
        MODE_CHAR,
        MODE_HEX,
        MODE_COPY
    } mode_t;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [3:0]       len_reg;
    logic [3:0]       len_next;
    logic [3:0]       pos_reg;
    logic [7:0]       ch_reg;
    logic [7:0]       ch_next;
    logic [15:0]      unit0_reg;
    logic [15:0]      unit0_next;
    logic [15:0]      unit1_reg;
    logic [15:0]      unit1_next;
    logic [3:0][7:0]  src_reg;
    logic             job_rl_reg;
    logic             job_sd_reg;
    logic             active_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_rl_reg;
    logic             out_sd_reg;

    logic             slot_free;
    logic             emit;
    logic             at_end;
    logic             load;
    logic [7:0]       esc_ch;
    logic             has_esc;
    logic [CP_W-1:0]  cp;
    logic [CP_W-1:0]  supp;
    logic             unit_sel;
    logic [3:0]       digit;
    logic [15:0]      unit;
    logic [7:0]       cur_byte;

    assign slot_free = !out_valid_reg || pop;
    assign emit      = active_reg && slot_free;
    assign at_end    = (pos_reg == len_reg - 4'd1);
    assign load      = !job_empty && (!active_reg || (emit && at_end));
    assign job_pop   = load;

    assign cp   = job_data.code_point;
    assign supp = cp - CP_SUPP_BASE;

    always_comb
    begin
        has_esc = 1'b1;
        case (cp)
            CP_BSLASH: esc_ch = CH_BSLASH;
            CP_QUOTE:  esc_ch = CH_QUOTE;
            CP_BS:     esc_ch = CH_LOW_B;
            CP_FF:     esc_ch = CH_LOW_F;
            CP_LF:     esc_ch = CH_LOW_N;
            CP_CR:     esc_ch = CH_LOW_R;
            CP_TAB:    esc_ch = CH_LOW_T;
            default:
            begin
                esc_ch  = 8'h00;
                has_esc = 1'b0;
            end
        endcase
    end

    // Classify the code point at the head of the queue.
    always_comb
    begin
        mode_next  = MODE_COPY;
        len_next   = {1'b0, job_data.src_count};
        ch_next    = esc_ch;
        unit0_next = cp[15:0];
        unit1_next = LO_SURR_BASE | {6'b0, supp[9:0]};
        if (has_esc)
        begin
            mode_next = MODE_SHORT;
            len_next  = 4'd2;
        end
        else if (ensure_ascii)
        begin
            if (cp >= CP_PRINT_MIN && cp <= CP_PRINT_MAX)
            begin
                mode_next = MODE_CHAR;
                len_next  = 4'd1;
                ch_next   = cp[7:0];
            end
            else if (cp <= CP_BMP_MAX)
            begin
                mode_next = MODE_HEX;
                len_next  = 4'd6;
            end
            else
            begin
                // Surrogate pair; the high unit keeps its low 16 bits only.
                mode_next  = MODE_HEX;
                len_next   = 4'd12;
                unit0_next = HI_SURR_BASE + {5'b0, supp[20:10]};
            end
        end
        else if (cp <= CP_CTRL_MAX)
        begin
            mode_next = MODE_HEX;
            len_next  = 4'd6;
        end
    end

    assign unit_sel = (pos_reg >= 4'd6);
    assign digit    = unit_sel ? pos_reg - 4'd6 : pos_reg;
    assign unit     = unit_sel ? unit1_reg : unit0_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_SHORT: cur_byte = (pos_reg == 4'd0) ? CH_BSLASH : ch_reg;
            MODE_CHAR:  cur_byte = ch_reg;
            MODE_COPY:  cur_byte = src_reg[pos_reg[1:0]];
            MODE_HEX:
            begin
                case (digit)
                    4'd0:    cur_byte = CH_BSLASH;
                    4'd1:    cur_byte = CH_LOW_U;
                    4'd2:    cur_byte = hex_char(unit[15:12]);
                    4'd3:    cur_byte = hex_char(unit[11:8]);
                    4'd4:    cur_byte = hex_char(unit[7:4]);
                    default: cur_byte = hex_char(unit[3:0]);
                endcase
            end
            default:    cur_byte = ch_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_COPY;
            len_reg       <= 4'd1;
            pos_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_rl_reg    <= 1'b0;
            out_sd_reg    <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mode_reg   <= mode_next;
                len_reg    <= len_next;
                pos_reg    <= '0;
                active_reg <= 1'b1;
            end
            else if (emit)
            begin
                pos_reg    <= pos_reg + 4'd1;
                active_reg <= !at_end;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_rl_reg    <= at_end && job_rl_reg;
                out_sd_reg    <= at_end && job_sd_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ch_reg     <= ch_next;
            unit0_reg  <= unit0_next;
            unit1_reg  <= unit1_next;
            src_reg    <= job_data.src_bytes;
            job_rl_reg <= job_data.run_last;
            job_sd_reg <= job_data.string_done;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = out_rl_reg;
    assign string_done = out_sd_reg;

    `ASSERT_CLK(a_pos_in_range, active_reg |-> (pos_reg < len_reg),
        "expander position past the end of its sequence")
    `ASSERT_CLK(a_done_is_last, (!empty && string_done) |-> run_last,
        "end of string flagged on a byte that does not end its run")

endmodule

FILE: rtl/utf8_json_string_escaper_core.sv
// Top level of the UTF-8 JSON string body escaper.
//
//   Channel   Handshake              Payload
//   input     push / full            in_byte, end_of_string
//   result    pop / empty            out_byte, run_last, string_done
//   config    cfg_valid / cfg_ready  cfg_ensure_ascii
//
// The rate is set by the expander, which sends one output byte per cycle while the
// result side is not stalled (up to 24 for one input byte), and by the decoder, which
// queues one code point per cycle while the job queue has room (up to 4 per input byte).
// Output passes through the job queue, the expander registers and the output register.
// Reset clears the decoder state, the job queue and the output register; held bytes need no clearing.
// The job queue lets the decoder run ahead while the result side is stalled.
module utf8_json_string_escaper_core
    import uje_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done,
    output logic       empty,
    input  logic       pop,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_ensure_ascii
);

    logic     ensure_ascii_reg;
    uje_job_t wr_job;
    uje_job_t rd_job;
    logic     job_push;
    logic     job_pop;
    logic     job_full;
    logic     job_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ensure_ascii_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ensure_ascii_reg <= cfg_ensure_ascii;
        end
    end

    uje_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .full          (full),
        .job_data      (wr_job),
        .job_push      (job_push),
        .job_full      (job_full)
    );

    uje_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (wr_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (rd_job),
        .empty   (job_empty)
    );

    uje_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ensure_ascii (ensure_ascii_reg),
        .job_data     (rd_job),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .string_done  (string_done),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
